@@ hdl/pni_pkg.sv @@
package pni_pkg;

    localparam int DATA_W      = 8;
    localparam int STATE_W     = 32;
    localparam int MOD_W       = 31;
    localparam int CFG_IDX_W   = 1;
    localparam int MOD_STEPS   = STATE_W;
    localparam int MOD_CNT_W   = $clog2(MOD_STEPS + 1);

    localparam logic [MOD_W-1:0]     RAND_BASE   = MOD_W'(10001);
    localparam logic [CFG_IDX_W-1:0] CFG_CORRUPT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DROP    = CFG_IDX_W'(1);

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [MOD_W-1:0] rem;
    } t_mod_status;

endpackage

@@ hdl/pni_in_if.sv @@
interface pni_in_if;
    import pni_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              first_of_packet;
    logic              last_of_packet;

    modport source (output valid, output data_byte, output first_of_packet,
                    output last_of_packet, input ready);
    modport sink   (input valid, input data_byte, input first_of_packet,
                    input last_of_packet, output ready);
endinterface

interface pni_out_if;
    import pni_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] byte_out;
    logic              dropped;
    logic              end_of_packet;

    modport source (output valid, output byte_out, output dropped,
                    output end_of_packet, input ready);
    modport sink   (input valid, input byte_out, input dropped,
                    input end_of_packet, output ready);
endinterface

@@ hdl/pni_mod_unit.sv @@
module pni_mod_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pni_pkg::STATE_W-1:0] i_dividend,
    input  logic [pni_pkg::MOD_W-1:0]   i_divisor,
    output pni_pkg::t_mod_status      o_status
);
    import pni_pkg::*;

    logic [STATE_W-1:0]   r_dvd;
    logic [MOD_W-1:0]     r_div;
    logic [MOD_W-1:0]     r_rem;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [STATE_W-1:0]   s_trial;
    logic [STATE_W:0]     s_diff;

    // one dividend bit shifts into the partial remainder per cycle
    assign s_trial = {r_rem, r_dvd[STATE_W-1]};
    assign s_diff  = {1'b0, s_trial} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= MOD_CNT_W'(MOD_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - MOD_CNT_W'(1);
                if (r_cnt == MOD_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[STATE_W-2:0], 1'b0};
            if (!s_diff[STATE_W]) begin
                r_rem <= s_diff[MOD_W-1:0];
            end else begin
                r_rem <= s_trial[MOD_W-1:0];
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_status.rem  = r_rem;

endmodule

@@ hdl/packet_noise_injector_unit.sv @@
// channel  | dir | beat payload                                 | handshake
// ---------+-----+----------------------------------------------+-------------
// i_in     | in  | data_byte[7:0] first_of_packet last_of_packet| valid/ready
// o_out    | out | byte_out[7:0] dropped end_of_packet          | valid/ready
// cfg      | in  | i_cfg_idx i_cfg_data[30:0]                   | i_cfg_we
//
// one beat at a time: a byte that does not start a packet goes through at most one
// remainder, a first byte up to three plus sequencing; the next input beat is taken
// in the cycle after the result is loaded; the remainders come from the bit-serial
// remainder unit: 32 steps per remainder
// synchronous active-low reset clears the state word, latched modulus and drop flag
// a stalled output holds its beat; the next input beat is taken while it waits
module packet_noise_injector_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pni_in_if.sink                        i_in,
    pni_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [pni_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pni_pkg::MOD_W-1:0]     i_cfg_data
);
    import pni_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_RAND_GO   = 4'd1;
    localparam logic [3:0] ST_RAND_WAIT = 4'd2;
    localparam logic [3:0] ST_DROP_GO   = 4'd3;
    localparam logic [3:0] ST_DROP_WAIT = 4'd4;
    localparam logic [3:0] ST_BODY      = 4'd5;
    localparam logic [3:0] ST_CORR_GO   = 4'd6;
    localparam logic [3:0] ST_CORR_WAIT = 4'd7;
    localparam logic [3:0] ST_OUT       = 4'd8;

    logic [3:0]         r_st, n_st;
    logic [MOD_W-1:0]   r_corrupt;
    logic [MOD_W-1:0]   r_drop;
    logic [STATE_W-1:0] r_state, n_state;
    logic [MOD_W-1:0]   r_pmod, n_pmod;
    logic               r_drop_act, n_drop_act;
    logic [DATA_W-1:0]  r_byte;
    logic               r_first;
    logic               r_last;
    logic [DATA_W-1:0]  r_res, n_res;
    logic               r_out_valid, n_out_valid;
    logic [DATA_W-1:0]  r_out_byte;
    logic               r_out_drop;
    logic               r_out_eop;

    logic               s_mod_start;
    logic [STATE_W-1:0] s_mod_dvd;
    logic [MOD_W-1:0]   s_mod_div;
    t_mod_status        s_mod;
    logic               s_accept;
    logic               s_load_out;

    pni_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_mod_start),
        .i_dividend (s_mod_dvd),
        .i_divisor  (s_mod_div),
        .o_status   (s_mod)
    );

    assign i_in.ready = (r_st == ST_IDLE);
    assign s_accept   = i_in.valid && i_in.ready;
    assign s_load_out = (r_st == ST_OUT) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_st        = r_st;
        n_state     = r_state;
        n_pmod      = r_pmod;
        n_drop_act  = r_drop_act;
        n_res       = r_res;
        s_mod_start = 1'b0;
        s_mod_dvd   = r_state;
        s_mod_div   = r_pmod;
        case (r_st)
            ST_IDLE: begin
                if (s_accept) begin
                    n_st = i_in.first_of_packet ? ST_RAND_GO : ST_BODY;
                end
            end
            ST_RAND_GO: begin
                n_drop_act = 1'b0;
                if (r_corrupt != '0) begin
                    n_pmod = r_corrupt;
                    n_st   = ST_DROP_GO;
                end else begin
                    s_mod_start = 1'b1;
                    s_mod_div   = RAND_BASE;
                    n_st        = ST_RAND_WAIT;
                end
            end
            ST_RAND_WAIT: begin
                if (s_mod.done) begin
                    n_pmod = s_mod.rem + MOD_W'(1);
                    n_st   = ST_DROP_GO;
                end
            end
            ST_DROP_GO: begin
                if (r_drop != '0) begin
                    s_mod_start = 1'b1;
                    s_mod_div   = r_drop;
                    n_st        = ST_DROP_WAIT;
                end else begin
                    n_st = ST_BODY;
                end
            end
            ST_DROP_WAIT: begin
                if (s_mod.done) begin
                    if (s_mod.rem == '0) begin
                        n_state    = r_state + STATE_W'(1);
                        n_drop_act = 1'b1;
                    end
                    n_st = ST_BODY;
                end
            end
            ST_BODY: begin
                if (r_drop_act) begin
                    n_res = '0;
                    n_st  = ST_OUT;
                end else begin
                    n_state = r_state + STATE_W'(r_byte) + STATE_W'(1);
                    n_res   = r_byte;
                    // no corruption before the first packet start
                    n_st    = (r_pmod != '0) ? ST_CORR_GO : ST_OUT;
                end
            end
            ST_CORR_GO: begin
                s_mod_start = 1'b1;
                n_st        = ST_CORR_WAIT;
            end
            ST_CORR_WAIT: begin
                if (s_mod.done) begin
                    if (s_mod.rem == '0) begin
                        n_res = r_state[DATA_W-1:0];
                    end
                    n_st = ST_OUT;
                end
            end
            ST_OUT: begin
                if (s_load_out) begin
                    n_st = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_out.valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (s_load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_state     <= '0;
            r_pmod      <= '0;
            r_drop_act  <= 1'b0;
            r_out_valid <= 1'b0;
            r_corrupt   <= '0;
            r_drop      <= '0;
        end else begin
            r_st        <= n_st;
            r_state     <= n_state;
            r_pmod      <= n_pmod;
            r_drop_act  <= n_drop_act;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CORRUPT: r_corrupt <= i_cfg_data;
                    CFG_DROP:    r_drop    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (s_accept) begin
            r_byte  <= i_in.data_byte;
            r_first <= i_in.first_of_packet;
            r_last  <= i_in.last_of_packet;
        end
        if (s_load_out) begin
            r_out_byte <= r_res;
            r_out_drop <= r_drop_act;
            r_out_eop  <= r_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.byte_out      = r_out_byte;
    assign o_out.dropped       = r_out_drop;
    assign o_out.end_of_packet = r_out_eop;

    // the remainder unit never runs while a new beat may enter
    a_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !s_mod.busy)
        else $error("remainder unit busy while input ready");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_mod_start |-> (s_mod_div != '0))
        else $error("remainder started with zero divisor");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.dropped) |-> (o_out.byte_out == '0))
        else $error("dropped beat carries nonzero byte");

    // the drop test only follows a first byte
    a_drop_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DROP_GO) |-> r_first)
        else $error("drop test outside packet start");

endmodule

@@ sim/packet_noise_injector_unit_test.sv @@
module packet_noise_injector_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pni_pkg::*;

    localparam int HOLD_CYCLES     = 400;
    localparam int STALL_LIMIT     = 5000;
    localparam int DRAIN_CYCLES    = 120;
    localparam int SETTLE_CYCLES   = 20;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 134;
    localparam int MAX_PRINTED     = 40;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              first;
        logic              last;
    } pkt_byte_t;

    typedef struct packed {
        logic [DATA_W-1:0] byte_out;
        logic              dropped;
        logic              eop;
    } noisy_beat_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [MOD_W-1:0]     i_cfg_data;

    pni_in_if  in_bus();
    pni_out_if out_bus();

    packet_noise_injector_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // mirror of the injector state and its registers
    logic [STATE_W-1:0] noise_word  = '0;
    logic [MOD_W-1:0]   pkt_mod     = '0;
    logic               dropping    = 1'b0;
    logic [MOD_W-1:0]   cfg_corrupt = '0;
    logic [MOD_W-1:0]   cfg_drop    = '0;

    pkt_byte_t   pending_bytes[$];
    noisy_beat_t expected_beats[$];

    int error_count       = 0;
    int bytes_queued      = 0;
    int beats_in          = 0;
    int beats_out         = 0;
    int packets_seen      = 0;
    int bytes_dropped     = 0;
    int bytes_overwritten = 0;
    int settings_used     = 0;
    int idle_cycles       = 0;
    int holds_asked       = 0;
    int holds_done        = 0;
    int hold_left         = 0;
    int src_gap           = 0;
    int sink_gap          = 0;
    bit in_taken          = 1'b0;
    bit idling            = 1'b1;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic noisy_beat_t inject_noise(pkt_byte_t b);
        noisy_beat_t r;
        r.byte_out = b.data_byte;
        r.eop      = b.last;
        if (b.first) begin
            if (cfg_corrupt != '0) begin
                pkt_mod = cfg_corrupt;
            end else begin
                pkt_mod = MOD_W'((noise_word % STATE_W'(RAND_BASE)) + STATE_W'(1));
            end
            dropping = 1'b0;
            if (cfg_drop != '0 && (noise_word % {1'b0, cfg_drop}) == '0) begin
                noise_word = noise_word + STATE_W'(1);
                dropping   = 1'b1;
            end
        end
        if (dropping) begin
            r.byte_out = '0;
            bytes_dropped++;
        end else begin
            noise_word = noise_word + STATE_W'(b.data_byte) + STATE_W'(1);
            if (pkt_mod != '0 && (noise_word % {1'b0, pkt_mod}) == '0) begin
                r.byte_out = noise_word[DATA_W-1:0];
                bytes_overwritten++;
            end
        end
        r.dropped = dropping;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        if (error_count < MAX_PRINTED)
            $display("mismatch: %s", what);
        error_count++;
    endtask

    // mostly short gaps, now and then a long one; no gaps while idling is clear
    function automatic int draw_gap();
        int roll;
        if (!idling)
            return 0;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    function automatic void queue_byte(logic [DATA_W-1:0] d, logic f, logic l);
        pkt_byte_t b;
        b.data_byte = d;
        b.first     = f;
        b.last      = l;
        pending_bytes.push_back(b);
        bytes_queued++;
    endfunction

    function automatic void queue_random_traffic(int count);
        int added;
        int roll;
        int len;
        added = 0;
        while (added < count) begin
            roll = $urandom_range(99);
            if (roll < 85) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    queue_byte(DATA_W'($urandom_range(255)), k == 0, k == len - 1);
            end else if (roll < 93) begin
                len = 1;
                queue_byte(DATA_W'($urandom_range(255)), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            end else begin
                // packet that never closes
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                    queue_byte(DATA_W'($urandom_range(255)), k == 0, 1'b0);
            end
            added += len;
        end
    endfunction

    task automatic wait_drained(int settle);
        while (beats_out < bytes_queued)
            @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic program_moduli(logic [MOD_W-1:0] corrupt, logic [MOD_W-1:0] drop);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CORRUPT;
        i_cfg_data <= corrupt;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_DROP;
        i_cfg_data <= drop;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_corrupt = corrupt;
        cfg_drop    = drop;
        settings_used++;
    endtask

    always @(negedge i_clk) begin : drive_bytes
        pkt_byte_t nxt;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (in_bus.valid && !in_taken) begin
            // beat still waiting for ready
        end else if (src_gap != 0) begin
            src_gap--;
            in_bus.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
            nxt = pending_bytes.pop_front();
            in_bus.data_byte       <= nxt.data_byte;
            in_bus.first_of_packet <= nxt.first;
            in_bus.last_of_packet  <= nxt.last;
            in_bus.valid           <= 1'b1;
            src_gap = draw_gap();
        end else begin
            in_bus.valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin : drive_ready
        if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_bus.ready <= 1'b0;
        end else if (sink_gap != 0) begin
            sink_gap--;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
            sink_gap = draw_gap();
        end
    end

    always @(posedge i_clk) begin : watch_channels
        pkt_byte_t   seen;
        noisy_beat_t want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            idle_cycles++;
            if (in_bus.valid && in_bus.ready) begin
                in_taken       = 1'b1;
                idle_cycles    = 0;
                seen.data_byte = in_bus.data_byte;
                seen.first     = in_bus.first_of_packet;
                seen.last      = in_bus.last_of_packet;
                beats_in++;
                if (seen.first)
                    packets_seen++;
                expected_beats.push_back(inject_noise(seen));
            end
            if (out_bus.valid && out_bus.ready) begin
                idle_cycles = 0;
                beats_out++;
                if (expected_beats.size() == 0) begin
                    report_mismatch($sformatf("beat %0d arrived with nothing expected",
                                              beats_out));
                end else begin
                    want = expected_beats.pop_front();
                    if (out_bus.byte_out !== want.byte_out)
                        report_mismatch($sformatf("beat %0d byte_out expected 0x%02h got 0x%02h",
                                                  beats_out, want.byte_out, out_bus.byte_out));
                    if (out_bus.dropped !== want.dropped)
                        report_mismatch($sformatf("beat %0d dropped expected %0b got %0b",
                                                  beats_out, want.dropped, out_bus.dropped));
                    if (out_bus.end_of_packet !== want.eop)
                        report_mismatch($sformatf("beat %0d end_of_packet expected %0b got %0b",
                                                  beats_out, want.eop, out_bus.end_of_packet));
                end
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("no beat moved for %0d cycles, %0d of %0d beats out",
                 STALL_LIMIT, beats_out, bytes_queued);
        $display("packet_noise_injector_unit_test: FAIL");
        $finish;
    end

    initial begin : run_test
        logic [MOD_W-1:0] corrupt_plan [PHASES];
        logic [MOD_W-1:0] drop_plan    [PHASES];
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = CFG_CORRUPT;
        i_cfg_data             = '0;
        in_bus.valid           = 1'b0;
        in_bus.data_byte       = '0;
        in_bus.first_of_packet = 1'b0;
        in_bus.last_of_packet  = 1'b0;
        out_bus.ready          = 1'b0;
        corrupt_plan = '{31'd0, 31'd1, 31'd3, 31'd0, 31'h7FFF_FFFF, MOD_W'($urandom()),
                         31'd0, 31'd7, MOD_W'($urandom_range(2, 300))};
        drop_plan    = '{31'd0, 31'd0, 31'd5, 31'd2, 31'h7FFF_FFFF,
                         MOD_W'($urandom_range(2, 9)), 31'd1, 31'd3, MOD_W'($urandom())};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset moduli: bytes ahead of any packet start are never replaced
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'h80, 1'b0, 1'b0);
        queue_byte(8'h01, 1'b0, 1'b1);
        queue_byte(8'hAA, 1'b1, 1'b1);
        // trailing bytes keep the previous packet going
        queue_byte(8'h55, 1'b0, 1'b0);
        queue_byte(8'h33, 1'b0, 1'b1);
        queue_byte(8'h10, 1'b1, 1'b0);
        wait_drained(SETTLE_CYCLES);
        // new modulus only counts from the next packet start
        program_moduli(31'd1, 31'd0);
        queue_byte(8'h20, 1'b0, 1'b0);
        queue_byte(8'h30, 1'b0, 1'b1);
        queue_byte(8'hFE, 1'b1, 1'b0);
        queue_byte(8'h7F, 1'b0, 1'b1);
        wait_drained(SETTLE_CYCLES);
        program_moduli(31'h7FFF_FFFF, 31'd1);
        queue_byte(8'hC3, 1'b1, 1'b0);
        queue_byte(8'h3C, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'hFF, 1'b1, 1'b1);
        wait_drained(SETTLE_CYCLES);
        program_moduli(31'd2, 31'h7FFF_FFFF);
        queue_byte(8'h12, 1'b1, 1'b0);
        queue_byte(8'h34, 1'b0, 1'b0);
        queue_byte(8'h56, 1'b0, 1'b1);
        queue_byte(8'hAB, 1'b1, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained(SETTLE_CYCLES);
            program_moduli(corrupt_plan[p], drop_plan[p]);
            idling = (p != 0 && p != 5);
            queue_random_traffic(ITEMS_PER_PHASE);
            // long receiver hold-off while the sender keeps offering
            if (p == 3 || p == 7)
                holds_asked++;
        end

        wait_drained(DRAIN_CYCLES);
        if (expected_beats.size() != 0)
            report_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));

        $display("ran %0d bytes in %0d packet starts across %0d modulus settings",
                 beats_in, packets_seen, settings_used);
        $display("%0d bytes dropped, %0d overwritten with state bits, %0d receiver hold-offs",
                 bytes_dropped, bytes_overwritten, holds_done);
        if (error_count == 0) begin
            $display("packet_noise_injector_unit_test: PASS");
        end else begin
            $display("packet_noise_injector_unit_test: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/pni_pkg.sv
hdl/pni_in_if.sv
hdl/pni_mod_unit.sv
hdl/packet_noise_injector_unit.sv
sim/packet_noise_injector_unit_test.sv
